>>> sv/lzwd_pkg.sv
// lzwd_pkg: shared types and constants for the LZSS window decompressor.
// No dependencies; imported by lzss_window_decompressor.
package lzwd_pkg;

   localparam int unsigned COUNT_W = 24;   // produced count and output limit
   localparam int unsigned DIST_W  = 12;   // back distance from pointer
   localparam int unsigned RUN_W   = 5;    // run length 3..18
   localparam int unsigned BYTE_W  = 8;

   localparam logic [BYTE_W-1:0]  FILL_BYTE   = 8'h20;   // space for reads before start
   localparam logic [RUN_W-1:0]   MIN_RUN     = 5'd3;
   localparam logic [COUNT_W-1:0] LIMIT_RESET = 24'hFF_FFFF;
   localparam logic [3:0]         TOK_FLAG    = 4'd8;    // next byte is a flag byte

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } state_type;

endpackage

>>> sv/lzwd_ram.sv
// lzwd_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module lzwd_ram #(
   parameter int unsigned DATA_W = 8,
   parameter int unsigned DEPTH  = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];   // read-before-write on same address
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/lzss_window_decompressor.sv
// lzss_window_decompressor: LZSS stream decoder with a 4 KiB history window.
// Depends on lzwd_pkg and lzwd_ram.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------
//  req     | in  | req_tvalid/req_tready  | tdata[7:0] in_byte, tlast last_in
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata[7:0] out_byte, tlast run_end
//  csr     | in  | csr_valid/csr_ready    | data[23:0] output_limit
//
// A flag byte, pointer low byte or literal is done when it is accepted. Once a
// pointer high byte is accepted, the first window read is issued and then the
// run bytes are emitted in order, held while rsp stalls. The single read port
// of the window RAM paces the copy: each byte is read while the one before it
// is emitted, and the byte written in the same cycle is forwarded for distance one.
// Reset: the window needs no clearing pass. A fill count tracks the
// prefix of addresses ever written (each stream writes from address 0 up) and
// unwritten entries read as zero.
// Stalls: a held rsp word freezes the copy and blocks req; csr is always ready.
module lzss_window_decompressor #(
   parameter int unsigned WINDOW_SIZE = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   // input words
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] in_byte
   input  logic                           req_tlast,   // last_in
   // result words
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // [7:0] out_byte
   output logic                           rsp_tlast,   // run_end
   // output limit register
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lzwd_pkg::COUNT_W-1:0]   csr_data
);
   import lzwd_pkg::*;

   localparam int unsigned AddrW = $clog2(WINDOW_SIZE);
   localparam int unsigned FillW = AddrW + 1;
   localparam logic [FillW-1:0] FillMax = FillW'(WINDOW_SIZE);

   // ---------------- registers ----------------
   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   limit_ff;
   logic [COUNT_W-1:0]   pc_ff, pc_in;          // bytes produced in this stream
   logic [FillW-1:0]     fill_ff, fill_in;      // window prefix ever written
   logic [BYTE_W-1:0]    flag_ff, flag_in;
   logic [3:0]           tok_ff, tok_in;
   logic                 phase_ff, phase_in;
   logic [BYTE_W-1:0]    low_ff, low_in;
   // copy engine
   logic [DIST_W-1:0]    dist_ff, dist_in;
   logic [RUN_W-1:0]     rem_ff, rem_in;
   logic                 last_ff, last_in;      // stream ends after this run
   logic                 pend_ff, pend_in;      // read data for next byte is ready
   logic                 space_ff, space_in;    // whole run is space fill
   logic                 vld_ff, vld_in;
   logic                 hit_ff, hit_in;
   logic [BYTE_W-1:0]    hitdata_ff, hitdata_in;
   // output register
   logic                 out_vld_ff, out_vld_in;
   logic [BYTE_W-1:0]    out_byte_ff, out_byte_in;
   logic                 out_end_ff, out_end_in;

   // ---------------- window RAM ----------------
   logic                 wr_en;
   logic [AddrW-1:0]     wr_addr;
   logic [BYTE_W-1:0]    wr_data;
   logic                 rd_en;
   logic [AddrW-1:0]     rd_addr;
   logic [BYTE_W-1:0]    rd_data;

   lzwd_ram #(
      .DATA_W (BYTE_W),
      .DEPTH  (WINDOW_SIZE)
   ) u_window (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------- datapath helpers ----------------
   logic                 out_free;
   logic                 accept;
   logic                 emit;
   logic [BYTE_W-1:0]    emit_byte;
   logic                 emit_end;
   logic [COUNT_W-1:0]   pc_inc;
   logic                 below_limit;
   logic [AddrW-1:0]     raddr_now;
   logic [AddrW-1:0]     raddr_next;
   logic [BYTE_W-1:0]    run_byte;
   logic [DIST_W-1:0]    ptr_dist;
   logic [RUN_W-1:0]     ptr_len;

   assign out_free    = !out_vld_ff || rsp_tready;
   assign req_tready  = (state_ff == ST_IDLE) && out_free;
   assign accept      = req_tvalid && req_tready;
   assign csr_ready   = 1'b1;

   assign pc_inc      = pc_ff + COUNT_W'(1);
   assign below_limit = pc_ff < limit_ff;
   assign raddr_now   = pc_ff[AddrW-1:0] - dist_ff[AddrW-1:0];
   assign raddr_next  = pc_inc[AddrW-1:0] - dist_ff[AddrW-1:0];
   assign run_byte    = space_ff ? FILL_BYTE :
                        hit_ff   ? hitdata_ff :
                        vld_ff   ? rd_data : '0;
   assign ptr_dist    = {req_tdata[7:4], low_ff};
   assign ptr_len     = RUN_W'(req_tdata[3:0]) + MIN_RUN;

   // window write follows every emitted byte
   assign wr_en   = emit;
   assign wr_addr = pc_ff[AddrW-1:0];
   assign wr_data = emit_byte;

   always_comb begin
      state_in    = state_ff;
      pc_in       = pc_ff;
      flag_in     = flag_ff;
      tok_in      = tok_ff;
      phase_in    = phase_ff;
      low_in      = low_ff;
      dist_in     = dist_ff;
      rem_in      = rem_ff;
      last_in     = last_ff;
      pend_in     = pend_ff;
      space_in    = space_ff;
      vld_in      = vld_ff;
      hit_in      = hit_ff;
      hitdata_in  = hitdata_ff;
      emit        = 1'b0;
      emit_byte   = req_tdata;
      emit_end    = 1'b1;
      rd_en       = 1'b0;
      rd_addr     = raddr_now;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (tok_ff[3]) begin
                  flag_in  = req_tdata;
                  tok_in   = '0;
                  phase_in = 1'b0;
               end else if (flag_ff[tok_ff[2:0]]) begin
                  // literal
                  if (below_limit) begin
                     emit  = 1'b1;
                     pc_in = pc_inc;
                  end
                  tok_in = tok_ff + 4'd1;
               end else if (!phase_ff) begin
                  low_in   = req_tdata;
                  phase_in = 1'b1;
               end else begin
                  // pointer complete: start the copy unless at the limit
                  phase_in = 1'b0;
                  tok_in   = tok_ff + 4'd1;
                  if (below_limit) begin
                     state_in = ST_RUN;
                     dist_in  = ptr_dist;
                     rem_in   = ptr_len;
                     last_in  = req_tlast;
                     pend_in  = 1'b0;
                  end
               end
               if (req_tlast) begin
                  tok_in   = TOK_FLAG;
                  phase_in = 1'b0;
                  flag_in  = '0;
                  if (!(phase_ff && !tok_ff[3] && !flag_ff[tok_ff[2:0]] && below_limit)) begin
                     pc_in = '0;
                  end
               end
            end
         end
         ST_RUN: begin
            if (!pend_ff) begin
               // first read of the run; a distance past the run start fills
               // the whole run with spaces
               rd_en    = 1'b1;
               rd_addr  = raddr_now;
               space_in = {{(COUNT_W-DIST_W){1'b0}}, dist_ff} > pc_ff;
               vld_in   = {1'b0, raddr_now} < fill_ff;
               hit_in   = 1'b0;
               pend_in  = 1'b1;
            end else if (out_free) begin
               emit      = 1'b1;
               emit_byte = run_byte;
               emit_end  = (rem_ff == RUN_W'(1)) || (pc_inc >= limit_ff);
               rem_in    = rem_ff - RUN_W'(1);
               if (emit_end) begin
                  state_in = ST_IDLE;
                  pend_in  = 1'b0;
                  pc_in    = last_ff ? '0 : pc_inc;
               end else begin
                  // read the next byte; forward the byte written this cycle
                  pc_in      = pc_inc;
                  rd_en      = 1'b1;
                  rd_addr    = raddr_next;
                  vld_in     = {1'b0, raddr_next} < fill_ff;
                  hit_in     = raddr_next == pc_ff[AddrW-1:0];
                  hitdata_in = run_byte;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // fill count grows by one when the write lands at its edge
   always_comb begin
      fill_in = fill_ff;
      if (emit && ({1'b0, wr_addr} == fill_ff)) begin
         fill_in = fill_ff + FillW'(1);
      end
   end

   // output register
   always_comb begin
      out_vld_in  = out_vld_ff;
      out_byte_in = out_byte_ff;
      out_end_in  = out_end_ff;
      if (emit) begin
         out_vld_in  = 1'b1;
         out_byte_in = emit_byte;
         out_end_in  = emit_end;
      end else if (rsp_tready) begin
         out_vld_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         limit_ff   <= LIMIT_RESET;
         pc_ff      <= '0;
         fill_ff    <= '0;
         flag_ff    <= '0;
         tok_ff     <= TOK_FLAG;
         phase_ff   <= 1'b0;
         low_ff     <= '0;
         pend_ff    <= 1'b0;
         last_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         limit_ff   <= (csr_valid && csr_ready) ? csr_data : limit_ff;
         pc_ff      <= pc_in;
         fill_ff    <= fill_in;
         flag_ff    <= flag_in;
         tok_ff     <= tok_in;
         phase_ff   <= phase_in;
         low_ff     <= low_in;
         pend_ff    <= pend_in;
         last_ff    <= last_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dist_ff     <= dist_in;
      rem_ff      <= rem_in;
      space_ff    <= space_in;
      vld_ff      <= vld_in;
      hit_ff      <= hit_in;
      hitdata_ff  <= hitdata_in;
      out_byte_ff <= out_byte_in;
      out_end_ff  <= out_end_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_end_ff;

   // ---------------- assertions ----------------
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FillMax)
      else $error("window fill count beyond window size");

   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> rem_ff != '0)
      else $error("copy running with no bytes left");

   a_emit_limit: assert property (@(posedge clock) disable iff (reset)
      emit |-> pc_ff < limit_ff)
      else $error("byte emitted at or past the output limit");

   a_stall_holds_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && pend_ff && !out_free) |=> (pend_ff && $stable(pc_ff)))
      else $error("copy advanced while result word stalled");

endmodule

>>> dv/lzwd_stream_checker.sv
// lzwd_stream_checker: watches the req, rsp and csr channels of the LZSS window
// decompressor, decodes each accepted input word and compares every rsp word.
// Depends on lzwd_pkg.
module lzwd_stream_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [7:0] in_byte
   input  logic                         req_tlast,   // last_in
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic [7:0]                   rsp_tdata,   // [7:0] out_byte
   input  logic                         rsp_tlast,   // run_end
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [lzwd_pkg::COUNT_W-1:0] csr_data,
   output int unsigned                  fail_count,
   output int unsigned                  pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import lzwd_pkg::*;

   localparam int WIN_DEPTH = 4096;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
   } out_word_type;

   out_word_type       expected_out [$];
   logic [7:0]         window_mem [0:WIN_DEPTH-1];
   logic [COUNT_W-1:0] emitted;
   logic [COUNT_W-1:0] limit_reg;
   logic [7:0]         flags;
   logic [3:0]         tok_idx;
   logic               ptr_held;
   logic [7:0]         ptr_lo;
   int unsigned        errs = 0;
   out_word_type       got;

   task automatic put_byte(input logic [7:0] v);
      window_mem[emitted[11:0]] = v;
      emitted = emitted + 1'b1;
   endtask

   // Decode one compressed byte and queue the bytes it expands to.
   task automatic decode_word(input logic [7:0] b, input logic last_w);
      logic [7:0]         run_bytes [0:17];
      int                 n;
      int                 i;
      logic [11:0]        back_dist;
      logic [4:0]         run_len;
      logic [COUNT_W-1:0] run_start;
      logic [COUNT_W-1:0] src;
      out_word_type       w;
      n = 0;
      if (tok_idx >= TOK_FLAG) begin
         flags    = b;
         tok_idx  = '0;
         ptr_held = 1'b0;
      end else if (flags[tok_idx[2:0]]) begin
         if (emitted < limit_reg) begin
            run_bytes[n] = b;
            put_byte(b);
            n++;
         end
         tok_idx = tok_idx + 1'b1;
      end else if (!ptr_held) begin
         ptr_lo   = b;
         ptr_held = 1'b1;
      end else begin
         back_dist = {b[7:4], ptr_lo};
         run_len   = {1'b0, b[3:0]} + MIN_RUN;
         run_start = emitted;
         for (i = 0; i < run_len && emitted < limit_reg; i++) begin
            // reads before the stream start give spaces; distance zero reads
            // the slot about to be overwritten
            if ({12'd0, back_dist} > run_start) begin
               run_bytes[n] = FILL_BYTE;
            end else begin
               src          = emitted - {12'd0, back_dist};
               run_bytes[n] = window_mem[src[11:0]];
            end
            put_byte(run_bytes[n]);
            n++;
         end
         ptr_held = 1'b0;
         tok_idx  = tok_idx + 1'b1;
      end
      for (i = 0; i < n; i++) begin
         w.out_byte = run_bytes[i];
         w.run_end  = (i == n - 1);
         expected_out.push_back(w);
      end
      if (last_w) begin
         tok_idx  = TOK_FLAG;
         ptr_held = 1'b0;
         flags    = '0;
         emitted  = '0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < WIN_DEPTH; a++) window_mem[a] = '0;
         emitted   = '0;
         limit_reg = LIMIT_RESET;
         flags     = '0;
         tok_idx   = TOK_FLAG;
         ptr_held  = 1'b0;
         ptr_lo    = '0;
         expected_out.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_out.size() == 0) begin
               $error("out_byte: expected none, actual %h (run_end %b)", rsp_tdata, rsp_tlast);
               errs++;
            end else begin
               got = expected_out.pop_front();
               if (rsp_tdata !== got.out_byte) begin
                  $error("out_byte: expected %h, actual %h", got.out_byte, rsp_tdata);
                  errs++;
               end
               if (rsp_tlast !== got.run_end) begin
                  $error("run_end: expected %b, actual %b", got.run_end, rsp_tlast);
                  errs++;
               end
            end
         end
         if (csr_valid && csr_ready) limit_reg = csr_data;
         if (req_tvalid && req_tready) decode_word(req_tdata, req_tlast);
      end
      fail_count    <= errs;
      pending_count <= expected_out.size();
   end

endmodule

>>> dv/tb_lzss_window_decompressor.sv
// tb_lzss_window_decompressor: drives compressed streams and output limits into
// the LZSS window decompressor and reports the verdict.
// Depends on lzwd_pkg, lzss_window_decompressor and lzwd_stream_checker.
module tb_lzss_window_decompressor;
   timeunit 1ns;
   timeprecision 1ps;

   import lzwd_pkg::*;

   localparam int SETTLE_CYCLES = 24;          // longest run is 18 bytes
   localparam int CYCLE_LIMIT   = 1_000_000;

   typedef enum logic [1:0] {
      TAIL_CLEAN,      // stream ends on a complete token
      TAIL_LONE_PTR,   // stream ends on a pointer low byte
      TAIL_FLAG_ONLY   // stream ends right after a flag byte
   } tail_kind_type;

   logic               clock;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata  = '0;     // [7:0] in_byte
   logic               req_tlast  = 1'b0;   // last_in
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [7:0]         rsp_tdata;           // [7:0] out_byte
   logic               rsp_tlast;           // run_end
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_data   = '0;

   int unsigned fail_count;
   int unsigned pending_count;

   // sender bookkeeping
   int          burst_left = 0;
   int          made;             // rough output count of the stream being built
   int unsigned words_sent = 0;

   // receiver stall pattern, rotated every cycle and reloaded when stall_epoch wraps
   logic [15:0] stall_pattern = 16'hFFFF;
   logic [7:0]  stall_epoch   = 8'd1;
   int unsigned cycle_count   = 0;

   lzss_window_decompressor uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   lzwd_stream_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: a 16-bit pattern with bit 0 forced set bounds each stall;
   // about a quarter of the epochs never stall.
   always @(posedge clock) begin
      stall_epoch <= stall_epoch + 1'b1;
      if (stall_epoch == 8'd0) begin
         stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                      : (16'($urandom) | 16'h0001);
      end else begin
         stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      end
      rsp_tready <= stall_pattern[0];
   end

   // Watchdog: a hung handshake or a missing result ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // One input word. Bursts of random length; an idle gap with valid low
   // opens each burst. Valid stays high across back-to-back words.
   task automatic send_word(input logic [7:0] b, input logic last_w);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last_w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      words_sent++;
   endtask

   // Hold off the sender until every expected word has come back, then
   // allow for a trailing word that produced nothing.
   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [COUNT_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly valid back references, some zero, some past the stream start.
   function automatic logic [11:0] pick_distance(input int made_so_far);
      int reach;
      int d;
      reach = (made_so_far > 4095) ? 4095 : made_so_far;
      case ($urandom_range(0, 9))
         0:       d = 0;
         1:       d = 4095;
         2:       d = (reach < 4095) ? $urandom_range(reach + 1, 4095) : 4095;
         default: d = (reach == 0) ? 1 : $urandom_range(1, reach);
      endcase
      return d[11:0];
   endfunction

   // Build one well-formed stream of n_tokens tokens and send it, last_in on
   // its final byte. runs_only gives max-length pointers throughout.
   task automatic send_stream(input int n_tokens, input tail_kind_type tail,
                              input bit runs_only);
      logic [7:0]  stream_q [$];
      logic [7:0]  flag_b;
      logic [3:0]  len_nib;
      logic [11:0] back_dist;
      int          t;
      int          i;
      made = 0;
      if (tail == TAIL_FLAG_ONLY) n_tokens = n_tokens - (n_tokens % 8);
      for (t = 0; t < n_tokens; t++) begin
         if (t % 8 == 0) begin
            flag_b = runs_only ? 8'h00 : 8'($urandom);
            // the dangling byte must land on a pointer token
            if (tail == TAIL_LONE_PTR && n_tokens - t < 8) flag_b[n_tokens - t] = 1'b0;
            stream_q.push_back(flag_b);
         end
         if (flag_b[t % 8]) begin
            stream_q.push_back(8'($urandom));
            made++;
         end else begin
            back_dist = pick_distance(made);
            len_nib   = runs_only ? 4'hF : 4'($urandom);
            stream_q.push_back(back_dist[7:0]);
            stream_q.push_back({back_dist[11:8], len_nib});
            made += len_nib + 3;
         end
      end
      case (tail)
         TAIL_LONE_PTR: begin
            if (n_tokens % 8 == 0) stream_q.push_back(8'($urandom) & 8'hFE);
            stream_q.push_back(8'($urandom));
         end
         TAIL_FLAG_ONLY: stream_q.push_back(8'($urandom));
         default: ;
      endcase
      for (i = 0; i < stream_q.size(); i++) send_word(stream_q[i], i == stream_q.size() - 1);
   endtask

   logic [COUNT_W-1:0] phase_limits [0:5];
   int unsigned        phase_start;
   int                 pick;

   initial begin
      phase_limits[0] = '0;
      phase_limits[1] = 24'd1;
      phase_limits[2] = 24'd7;
      phase_limits[3] = 24'd40;
      phase_limits[4] = 24'($urandom_range(50, 600));
      phase_limits[5] = LIMIT_RESET;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_limit(LIMIT_RESET);

      // --- directed ---
      // flag 1000_0011: literals on tokens 0, 1, 7, pointers on 2..6
      send_word(8'hA3 & 8'h83, 1'b0);
      send_word(8'h00, 1'b0);               // literal, all zeros
      send_word(8'hFF, 1'b0);               // literal, all ones
      send_word(8'h00, 1'b0);               // zero distance, len 3: stale window
      send_word(8'h00, 1'b0);
      send_word(8'h01, 1'b0);               // distance 1, len 18: overlapping copy
      send_word(8'h0F, 1'b0);
      send_word(8'hFF, 1'b0);               // distance 4095, len 18: all spaces
      send_word(8'hFF, 1'b0);
      send_word(8'h02, 1'b0);               // distance 2, len 4
      send_word(8'h01, 1'b0);
      send_word(8'h10, 1'b0);               // distance 0xF10, len 3: spaces
      send_word(8'hF0, 1'b0);
      send_word(8'h5A, 1'b0);               // literal
      send_word(8'h00, 1'b0);               // flag: all pointers
      send_word(8'h33, 1'b1);               // lone pointer low byte, dropped
      send_word(8'hA7, 1'b1);               // stream that is only a flag byte
      send_word(8'h01, 1'b0);               // one literal stream
      send_word(8'hA5, 1'b1);
      send_word(8'h00, 1'b0);               // zero distance into the previous
      send_word(8'h00, 1'b0);               // stream's window contents
      send_word(8'h02, 1'b1);

      // --- random phases, one output limit each ---
      for (int p = 0; p < 6; p++) begin
         drain_and_settle();
         write_limit(phase_limits[p]);
         phase_start = words_sent;
         while (words_sent - phase_start < 15) begin
            pick = $urandom_range(0, 19);
            if (pick < 3) begin
               // noise: arbitrary bytes, last one closes the stream
               for (int k = $urandom_range(1, 12); k > 0; k--) send_word(8'($urandom), k == 1);
            end else if (pick < 6) begin
               send_stream($urandom_range(1, 20), TAIL_LONE_PTR, 1'b0);
            end else if (pick < 8) begin
               send_stream($urandom_range(0, 16), TAIL_FLAG_ONLY, 1'b0);
            end else begin
               send_stream($urandom_range(1, 24), TAIL_CLEAN, 1'b0);
            end
         end
      end

      // one stream of back-to-back maximum-length runs
      drain_and_settle();
      send_stream(8, TAIL_CLEAN, 1'b1);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> lzss_window_decompressor.f
sv/lzwd_pkg.sv
sv/lzwd_ram.sv
sv/lzss_window_decompressor.sv
dv/lzwd_stream_checker.sv
dv/tb_lzss_window_decompressor.sv
